// ===== sv/rmed_pkg.sv =====
// Shared types and constants of the running median block.
package rmed_pkg;

    localparam int HELD_W = 11;

    typedef logic [HELD_W-1:0] t_held;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_PUSH,
        OP_INSPOP
    } t_op;

endpackage

// ===== sv/rmed_cell.sv =====
// One ordered storage cell with neighbour compare and shift.
module rmed_cell #(
    parameter int IDX    = 0,
    parameter bit DESC   = 1'b0,
    parameter int W      = 16,
    parameter int SIZE_W = 11
) (
    input  logic                 i_clk,
    input  rmed_pkg::t_op        i_op,
    input  logic signed [W-1:0]  i_value,
    input  logic [SIZE_W-1:0]    i_size,
    input  logic signed [W-1:0]  i_prev_val,
    input  logic                 i_prev_b,
    input  logic signed [W-1:0]  i_next_val,
    input  logic                 i_next_b,
    output logic signed [W-1:0]  o_val,
    output logic signed [W-1:0]  o_next,
    output logic                 o_b
);

    logic signed [W-1:0] r_val;
    logic signed [W-1:0] n_val;
    logic                occupied;
    logic                cmp;

    assign occupied = i_size > SIZE_W'(IDX);
    assign cmp      = DESC ? (r_val >= i_value) : (r_val <= i_value);
    assign o_b      = occupied && cmp;

    always_comb begin
        case (i_op)
            rmed_pkg::OP_HOLD: begin
                n_val = r_val;
            end
            rmed_pkg::OP_INSERT: begin
                if (o_b) begin
                    n_val = r_val;
                end else if (i_prev_b) begin
                    n_val = i_value;
                end else begin
                    n_val = i_prev_val;
                end
            end
            rmed_pkg::OP_PUSH: begin
                n_val = i_prev_val;
            end
            rmed_pkg::OP_INSPOP: begin
                if (i_next_b) begin
                    n_val = i_next_val;
                end else if (o_b) begin
                    n_val = i_value;
                end else begin
                    n_val = r_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

// ===== sv/rmed_chain.sv =====
// Row of ordered cells forming one half of the sample store.
module rmed_chain #(
    parameter int DEPTH  = 512,
    parameter bit DESC   = 1'b0,
    parameter int W      = 16,
    parameter int SIZE_W = 11
) (
    input  logic                 i_clk,
    input  rmed_pkg::t_op        i_op,
    input  logic signed [W-1:0]  i_value,
    input  logic signed [W-1:0]  i_push_value,
    input  logic [SIZE_W-1:0]    i_size,
    output logic signed [W-1:0]  o_head,
    output logic signed [W-1:0]  o_head_next
);

    logic signed [W-1:0] vals  [DEPTH];
    logic signed [W-1:0] nexts [DEPTH];
    logic                bs    [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [W-1:0] prev_val;
        logic                prev_b;
        logic signed [W-1:0] next_val;
        logic                next_b;

        if (k == 0) begin : g_first
            assign prev_val = i_push_value;
            assign prev_b   = 1'b1;
        end else begin : g_mid
            assign prev_val = vals[k-1];
            assign prev_b   = bs[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign next_val = vals[k];
            assign next_b   = 1'b0;
        end else begin : g_inner
            assign next_val = vals[k+1];
            assign next_b   = bs[k+1];
        end

        rmed_cell #(
            .IDX    (k),
            .DESC   (DESC),
            .W      (W),
            .SIZE_W (SIZE_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (i_op),
            .i_value    (i_value),
            .i_size     (i_size),
            .i_prev_val (prev_val),
            .i_prev_b   (prev_b),
            .i_next_val (next_val),
            .i_next_b   (next_b),
            .o_val      (vals[k]),
            .o_next     (nexts[k]),
            .o_b        (bs[k])
        );
    end

    assign o_head      = vals[0];
    assign o_head_next = nexts[0];

endmodule

// ===== sv/running_median.sv =====
// Top level of the running median: two ordered cell chains around the median.
// The result of an accepted input transaction is registered and on the outputs in the next cycle.
// Throughput: one transaction per cycle while the output is not stalled, set by the parallel
// compare and shift across every cell of the lower and upper chains plus the median adder.
// Reset clears the held count and the output valid; cell contents are left as they are
// and are only read once written. No clearing pass follows reset.
module running_median #(
    parameter int CAPACITY     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_WIDTH:0]  o_median_doubled,
    output rmed_pkg::t_held               o_held_count,
    output logic                          o_rejected
);

    localparam int W        = SAMPLE_WIDTH;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int LO_DEPTH = (CAPACITY + 1) / 2;
    localparam int UP_DEPTH = CAPACITY / 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    logic signed [W:0]   r_median;
    logic signed [W:0]   n_median;
    logic                r_rejected;
    logic                n_rejected;

    logic                accept;
    logic                full;
    logic                odd;
    logic                odd_after;
    logic [CW-1:0]       lo_size;
    logic [CW-1:0]       up_size;
    rmed_pkg::t_op       lo_op;
    rmed_pkg::t_op       up_op;
    logic signed [W-1:0] lo_push;
    logic signed [W-1:0] lo_head;
    logic signed [W-1:0] up_head;
    logic signed [W-1:0] lo_head_next;
    logic signed [W-1:0] up_head_next;
    logic                v_le_lo;
    logic                v_le_up;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = r_count == CAP_C;
    assign odd     = r_count[0];
    assign lo_size = CW'(({1'b0, r_count} + 1'b1) >> 1);
    assign up_size = r_count >> 1;
    assign v_le_lo = i_sample <= lo_head;
    assign v_le_up = i_sample <= up_head;

    always_comb begin
        lo_op   = rmed_pkg::OP_HOLD;
        up_op   = rmed_pkg::OP_HOLD;
        lo_push = v_le_up ? i_sample : up_head;
        if (accept && !full) begin
            if (r_count == '0) begin
                lo_op = rmed_pkg::OP_INSERT;
            end else if (v_le_lo) begin
                if (odd) begin
                    lo_op = rmed_pkg::OP_INSPOP;
                    up_op = rmed_pkg::OP_PUSH;
                end else begin
                    lo_op = rmed_pkg::OP_INSERT;
                end
            end else if (odd) begin
                up_op = rmed_pkg::OP_INSERT;
            end else if (v_le_up) begin
                lo_op = rmed_pkg::OP_PUSH;
            end else begin
                lo_op = rmed_pkg::OP_PUSH;
                up_op = rmed_pkg::OP_INSPOP;
            end
        end
    end

    rmed_chain #(
        .DEPTH  (LO_DEPTH),
        .DESC   (1'b1),
        .W      (W),
        .SIZE_W (CW)
    ) u_lower (
        .i_clk        (i_clk),
        .i_op         (lo_op),
        .i_value      (i_sample),
        .i_push_value (lo_push),
        .i_size       (lo_size),
        .o_head       (lo_head),
        .o_head_next  (lo_head_next)
    );

    rmed_chain #(
        .DEPTH  (UP_DEPTH),
        .DESC   (1'b0),
        .W      (W),
        .SIZE_W (CW)
    ) u_upper (
        .i_clk        (i_clk),
        .i_op         (up_op),
        .i_value      (i_sample),
        .i_push_value (lo_head),
        .i_size       (up_size),
        .o_head       (up_head),
        .o_head_next  (up_head_next)
    );

    assign odd_after = full ? odd : !odd;

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_median    = r_median;
        n_rejected  = r_rejected;
        if (accept) begin
            n_out_valid = 1'b1;
            n_rejected  = full;
            if (!full) begin
                n_count = r_count + 1'b1;
            end
            if (odd_after) begin
                n_median = {lo_head_next, 1'b0};
            end else begin
                n_median = {lo_head_next[W-1], lo_head_next}
                         + {up_head_next[W-1], up_head_next};
            end
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_median   <= n_median;
        r_rejected <= n_rejected;
    end

    assign o_valid          = r_out_valid;
    assign o_median_doubled = r_median;
    assign o_held_count     = rmed_pkg::t_held'(r_count);
    assign o_rejected       = r_rejected;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("held count beyond capacity");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full |=> o_valid && o_rejected && r_count == CAP_C)
        else $error("full store did not reject");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full |=> r_count == $past(r_count) + 1'b1 && !o_rejected)
        else $error("held count did not advance");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("held count moved without a transaction");

endmodule

// ===== tb/running_median_checker.sv =====
`timescale 1ns / 1ps
// Median checker: sorts accepted samples, predicts each result and compares the output.
module running_median_checker #(
    parameter int CAPACITY     = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [SAMPLE_WIDTH:0]   i_median_doubled,
    input  rmed_pkg::t_held                i_held_count,
    input  logic                           i_rejected,
    output int                             o_mismatches,
    output int                             o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH:0] median_doubled;
        rmed_pkg::t_held              held_count;
        logic                         rejected;
    } t_median_result;

    logic signed [SAMPLE_WIDTH-1:0] sorted_held [CAPACITY];
    int                             held_n = 0;
    t_median_result                 median_due [$];
    int                             mismatch_count = 0;

    function automatic t_median_result next_median(input logic signed [SAMPLE_WIDTH-1:0] s);
        t_median_result               r;
        int                           pos;
        logic signed [SAMPLE_WIDTH:0] lo;
        logic signed [SAMPLE_WIDTH:0] hi;
        r.rejected = (held_n >= CAPACITY);
        if (!r.rejected) begin
            pos = held_n;
            while (pos > 0 && sorted_held[pos-1] > s) begin
                sorted_held[pos] = sorted_held[pos-1];
                pos--;
            end
            sorted_held[pos] = s;
            held_n++;
        end
        lo = sorted_held[(held_n - 1) / 2];
        hi = sorted_held[held_n / 2];
        r.median_doubled = lo + hi;
        r.held_count     = rmed_pkg::t_held'(held_n);
        return r;
    endfunction

    always @(posedge i_clk) begin : compare
        t_median_result want;
        if (!i_rst_n) begin
            held_n = 0;
            median_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (median_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("running_median_checker: result with none due: ");
                        $display("median %0d held %0d rejected %0b",
                                 i_median_doubled, i_held_count, i_rejected);
                    end
                end else begin
                    want = median_due.pop_front();
                    if (want.median_doubled !== i_median_doubled ||
                        want.held_count !== i_held_count || want.rejected !== i_rejected) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("running_median_checker: mismatch: median exp %0d got %0d, ",
                                   want.median_doubled, i_median_doubled);
                            $display("held exp %0d got %0d, rejected exp %0b got %0b",
                                     want.held_count, i_held_count,
                                     want.rejected, i_rejected);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                median_due.push_back(next_median(i_sample));
        end
        o_mismatches = mismatch_count;
        o_pending    = median_due.size();
    end

endmodule

// ===== tb/running_median_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for running_median: clock, reset, sample and stall stimulus, and the verdict.
module running_median_tb;

    localparam int CAPACITY       = 1024;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int N_RANDOM       = 580;
    localparam int IDLE_MAX       = 14;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN          = 8;

    localparam logic signed [SAMPLE_WIDTH-1:0] DIRECTED [20] = '{
        16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hffff,
        16'h0001, 16'h5555, 16'haaaa, 16'h8000, 16'h7fff,
        16'hfffe, 16'h0002, 16'h4000, 16'hc000, 16'h0000
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_sample;
    logic                           o_valid;
    logic                           i_stall;
    logic signed [SAMPLE_WIDTH:0]   o_median_doubled;
    rmed_pkg::t_held                o_held_count;
    logic                           o_rejected;

    int mismatches;
    int pending;
    int quiet_cycles = 0;
    int send_burst   = 0;
    int recv_burst   = 0;

    running_median #(
        .CAPACITY     (CAPACITY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_median_doubled (o_median_doubled),
        .o_held_count     (o_held_count),
        .o_rejected       (o_rejected)
    );

    running_median_checker #(
        .CAPACITY     (CAPACITY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_sample         (i_sample),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_median_doubled (o_median_doubled),
        .i_held_count     (o_held_count),
        .i_rejected       (o_rejected),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        logic signed [SAMPLE_WIDTH-1:0] s;
        case ($urandom_range(0, 9)) inside
            0: begin
                case ($urandom_range(0, 3))
                    0:       s = 16'h8000;
                    1:       s = 16'h7fff;
                    2:       s = 16'hffff;
                    default: s = 16'h0000;
                endcase
            end
            [1:3]:   s = 16'($urandom_range(0, 16)) - 16'd8;
            4:       s = 16'h7ff0 + 16'($urandom_range(0, 15));
            default: s = 16'($urandom());
        endcase
        return s;
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_sample = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) send_sample(DIRECTED[k]);
        repeat (N_RANDOM) send_sample(pick_sample());
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (mismatches == 0)
            $display("running_median_tb: PASS");
        else
            $display("running_median_tb: FAIL");
        $finish;
    end

    initial begin : receiver
        int w;
        int taken;
        i_stall = 1'b0;
        taken   = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            w = draw_wait(recv_burst);
            // hold off long enough to back the block up into its input
            if (taken == 150 || taken == 450)
                w = HOLD_OFF;
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("running_median_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
